[hdl/lav_pkg.sv]
// ----------------------------------------------------------------------------
// lav_pkg: shared types and constants of the look-at view matrix block
// Fixed input format, internal magnitude scaling and row numbering.
// ----------------------------------------------------------------------------
package lav_pkg;

    // Input words are signed Q16.16
    localparam int IN_BITS  = 32;
    localparam int IN_FRAC  = 16;

    // Magnitudes are scaled so the largest one lies in [2^29, 2^30)
    localparam int MAG_BITS = 30;
    // Sum of three squared magnitudes and the square-root work word
    localparam int SQ_BITS  = 64;

    typedef logic [1:0] t_row_idx;

    localparam t_row_idx LAST_ROW = 2'd3;

endpackage

[hdl/lav_norm.sv]
// ----------------------------------------------------------------------------
// lav_norm: pipelined 3-vector normalizer
// Scales the magnitudes by a common power of two, takes the integer square
// root of the sum of squares one bit per stage, then divides each component
// by the length one quotient bit per stage. A sideband word rides along.
// ----------------------------------------------------------------------------
module lav_norm
    import lav_pkg::*;
#(
    parameter int IN_W   = 33,
    parameter int FRAC   = 16,
    parameter int SIDE_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [IN_W-1:0]   i_vec [3],
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output logic signed [FRAC+1:0]   o_vec [3],
    output logic                     o_zero,
    output logic [SIDE_W-1:0]        o_side
);

    localparam int TW    = $clog2(IN_W);
    localparam int XW    = IN_W + MAG_BITS;
    localparam int NB    = SQ_BITS / 2;
    localparam int NW    = MAG_BITS + 1;
    localparam int DW    = MAG_BITS + FRAC + 1;
    localparam int QB    = FRAC + 1;
    localparam int OW    = FRAC + 2;
    localparam int TAG_W = SIDE_W + 4;
    localparam int LAT   = 7 + NB + QB;

    // Tag chain: side word, three sign bits, zero flag
    logic             r_vld [1:LAT];
    logic [TAG_W-1:0] r_tag [1:LAT];

    // Stage payloads
    logic [IN_W-1:0]          r_a_mag [3];
    logic [IN_W-1:0]          r_b_mag [3];
    logic [TW-1:0]            r_b_top;
    logic [MAG_BITS-1:0]      r_c_m [3];
    logic [MAG_BITS-1:0]      r_d_m [3];
    logic [2*MAG_BITS-1:0]    r_d_sq [3];
    logic [SQ_BITS-1:0]       r_s   [0:NB];
    logic [SQ_BITS-1:0]       r_res [0:NB];
    logic [MAG_BITS-1:0]      r_sm  [0:NB][3];
    logic [DW-1:0]            r_rem [0:QB][3];
    logic [QB-1:0]            r_q   [0:QB][3];
    logic [NW-1:0]            r_dn  [0:QB];
    logic signed [OW-1:0]     r_out [3];

    logic [IN_W-1:0] or_all;
    logic            n_zero;
    logic [TW-1:0]   n_top;
    logic [2:0]      in_neg;

    // Flag an all-zero vector and find the top set bit over all magnitudes
    always_comb begin
        or_all = r_a_mag[0] | r_a_mag[1] | r_a_mag[2];
        n_zero = (or_all == '0);
        n_top  = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (or_all[i]) begin
                n_top = TW'(i);
            end
        end
    end

    assign in_neg = {i_vec[2][IN_W-1], i_vec[1][IN_W-1], i_vec[0][IN_W-1]};

    // Advance valid and tag with the data
    for (genvar t = 1; t <= LAT; t++) begin : g_tag
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[t] <= 1'b0;
            end else if (i_en) begin
                if (t == 1) begin
                    r_vld[t] <= i_valid;
                end else begin
                    r_vld[t] <= r_vld[t-1];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (t == 1) begin
                    r_tag[t] <= {i_side, in_neg, 1'b0};
                end else if (t == 2) begin
                    r_tag[t] <= {r_tag[t-1][TAG_W-1:1], n_zero};
                end else begin
                    r_tag[t] <= r_tag[t-1];
                end
            end
        end
    end

    // Take magnitudes, find the scale, scale, square, sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_a_mag[k] <= i_vec[k][IN_W-1] ? unsigned'(-i_vec[k]) : unsigned'(i_vec[k]);
                r_b_mag[k] <= r_a_mag[k];
                r_d_m[k]   <= r_c_m[k];
                r_d_sq[k]  <= r_c_m[k] * r_c_m[k];
                r_sm[0][k] <= r_d_m[k];
            end
            r_b_top <= n_top;
            r_s[0]  <= SQ_BITS'(r_d_sq[0]) + SQ_BITS'(r_d_sq[1]) + SQ_BITS'(r_d_sq[2]);
            r_res[0] <= '0;
        end
    end

    // Shift so the top set bit lands on bit MAG_BITS-1
    always_ff @(posedge i_clk) begin
        logic [XW-1:0]  wide;
        logic [TW:0]    amt;
        if (i_en) begin
            amt = {1'b0, r_b_top} + 1'b1;
            for (int k = 0; k < 3; k++) begin
                wide      = {r_b_mag[k], MAG_BITS'(0)} >> amt;
                r_c_m[k] <= wide[MAG_BITS-1:0];
            end
        end
    end

    // Integer square root, one result bit per stage
    for (genvar k = 1; k <= NB; k++) begin : g_sqrt
        localparam logic [SQ_BITS-1:0] BIT_K = SQ_BITS'(1) << (SQ_BITS - 2*k);
        logic [SQ_BITS-1:0] cand;
        assign cand = r_res[k-1] + BIT_K;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_s[k-1] >= cand) begin
                    r_s[k]   <= r_s[k-1] - cand;
                    r_res[k] <= (r_res[k-1] >> 1) + BIT_K;
                end else begin
                    r_s[k]   <= r_s[k-1];
                    r_res[k] <= r_res[k-1] >> 1;
                end
                r_sm[k] <= r_sm[k-1];
            end
        end
    end

    // Form rounded dividends from the length
    always_ff @(posedge i_clk) begin
        logic [NW-1:0] len;
        if (i_en) begin
            len = r_res[NB][NW-1:0];
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k] <= (DW'(r_sm[NB][k]) << FRAC) + DW'(len >> 1);
                r_q[0][k]   <= '0;
            end
            r_dn[0] <= len;
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar j = 1; j <= QB; j++) begin : g_div
        localparam int POS = QB - j;
        logic [DW-1:0] dsh;
        assign dsh = DW'(r_dn[j-1]) << POS;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[j-1][k] >= dsh) begin
                        r_rem[j][k] <= r_rem[j-1][k] - dsh;
                        r_q[j][k]   <= r_q[j-1][k] | (QB'(1) << POS);
                    end else begin
                        r_rem[j][k] <= r_rem[j-1][k];
                        r_q[j][k]   <= r_q[j-1][k];
                    end
                end
                r_dn[j] <= r_dn[j-1];
            end
        end
    end

    // Apply the signs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_out[k] <= r_tag[LAT-1][k+1] ? -signed'({1'b0, r_q[QB][k]})
                                              : signed'({1'b0, r_q[QB][k]});
            end
        end
    end

    assign o_valid = r_vld[LAT];
    assign o_vec   = r_out;
    assign o_zero  = r_tag[LAT][0];
    assign o_side  = r_tag[LAT][TAG_W-1:4];

endmodule

[hdl/look_at_view_matrix.sv]
// ----------------------------------------------------------------------------
// look_at_view_matrix: fixed-point look-at camera view matrix
// Builds the 4x4 view matrix from position, view and up vectors, row by row.
// ----------------------------------------------------------------------------
// Each accepted transaction yields four result transactions, rows 0 to 3 in
// order, so the single result channel, moving one row per cycle while i_ready
// is high, sets the sustained input rate. A new input is taken while the
// previous matrix is still being delivered. The path from input to row 0 is
// dominated by two normalizers, each with a one-bit-per-stage square root and
// one-bit-per-stage divider. A zero view vector, or an up vector parallel to
// it, gives the identity matrix with the degenerate flag set on all four rows.
// Every entry saturates to WORD_BITS.
module look_at_view_matrix
    import lav_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [IN_BITS-1:0]    i_pos_x,
    input  logic signed [IN_BITS-1:0]    i_pos_y,
    input  logic signed [IN_BITS-1:0]    i_pos_z,
    input  logic signed [IN_BITS-1:0]    i_view_x,
    input  logic signed [IN_BITS-1:0]    i_view_y,
    input  logic signed [IN_BITS-1:0]    i_view_z,
    input  logic signed [IN_BITS-1:0]    i_up_x,
    input  logic signed [IN_BITS-1:0]    i_up_y,
    input  logic signed [IN_BITS-1:0]    i_up_z,
    output logic                         o_valid,
    input  logic                         i_ready,
    output t_row_idx                     o_row_index,
    output logic signed [WORD_BITS-1:0]  o_col0,
    output logic signed [WORD_BITS-1:0]  o_col1,
    output logic signed [WORD_BITS-1:0]  o_col2,
    output logic signed [WORD_BITS-1:0]  o_col3,
    output logic                         o_degenerate,
    output logic                         o_last_row
);

    localparam int NVW   = IN_BITS + 1;
    localparam int WW    = FRAC_BITS + 2;
    localparam int CW    = IN_BITS + WW + 1;
    localparam int VW    = FRAC_BITS + 6;
    localparam int PW    = VW + IN_BITS;
    localparam int DSW   = PW + 2;
    localparam int TRW   = DSW - IN_FRAC + 1;
    localparam int EW0   = (TRW > WORD_BITS) ? TRW : WORD_BITS;
    localparam int EW    = ((EW0 > VW) ? EW0 : VW) + 1;
    localparam int SIDE1 = 6*IN_BITS + 1;
    localparam int SIDE2 = 3*IN_BITS + 3*WW + 1;

    localparam logic signed [EW-1:0] SAT_HI = (EW'(1) << (WORD_BITS-1)) - EW'(1);
    localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);
    localparam logic signed [EW-1:0] ONE    = EW'(1) << FRAC_BITS;

    function automatic logic [WORD_BITS-1:0] sat(input logic signed [EW-1:0] x);
        logic signed [EW-1:0] y;
        y = x;
        if (x > SAT_HI) begin
            y = SAT_HI;
        end else if (x < SAT_LO) begin
            y = SAT_LO;
        end
        return y[WORD_BITS-1:0];
    endfunction

    logic en;
    logic load;

    // Stage 1: parallel-test products and negated view
    logic                        r1_v;
    logic signed [IN_BITS-1:0]   r1_p [3];
    logic signed [IN_BITS-1:0]   r1_up [3];
    logic signed [NVW-1:0]       r1_nw [3];
    logic signed [2*IN_BITS-1:0] r1_x [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p[0]  <= i_pos_x;
            r1_p[1]  <= i_pos_y;
            r1_p[2]  <= i_pos_z;
            r1_up[0] <= i_up_x;
            r1_up[1] <= i_up_y;
            r1_up[2] <= i_up_z;
            r1_nw[0] <= -NVW'(i_view_x);
            r1_nw[1] <= -NVW'(i_view_y);
            r1_nw[2] <= -NVW'(i_view_z);
            r1_x[0]  <= i_up_y * i_view_z;
            r1_x[1]  <= i_up_z * i_view_y;
            r1_x[2]  <= i_up_z * i_view_x;
            r1_x[3]  <= i_up_x * i_view_z;
            r1_x[4]  <= i_up_x * i_view_y;
            r1_x[5]  <= i_up_y * i_view_x;
        end
    end

    // Stage 2: parallel test
    logic                      r2_v;
    logic signed [IN_BITS-1:0] r2_p [3];
    logic signed [IN_BITS-1:0] r2_up [3];
    logic signed [NVW-1:0]     r2_nw [3];
    logic                      r2_par;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p   <= r1_p;
            r2_up  <= r1_up;
            r2_nw  <= r1_nw;
            r2_par <= (r1_x[0] == r1_x[1]) && (r1_x[2] == r1_x[3]) && (r1_x[4] == r1_x[5]);
        end
    end

    // Normalize the negated view into w
    logic                      n1_v;
    logic signed [WW-1:0]      n1_w [3];
    logic                      n1_zero;
    logic [SIDE1-1:0]          n1_side;
    logic signed [IN_BITS-1:0] n1_p [3];
    logic signed [IN_BITS-1:0] n1_up [3];

    lav_norm #(
        .IN_W   (NVW),
        .FRAC   (FRAC_BITS),
        .SIDE_W (SIDE1)
    ) u_norm_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_vec   (r2_nw),
        .i_side  ({r2_p[0], r2_p[1], r2_p[2], r2_up[0], r2_up[1], r2_up[2], r2_par}),
        .o_valid (n1_v),
        .o_vec   (n1_w),
        .o_zero  (n1_zero),
        .o_side  (n1_side)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n1_p[k]  = n1_side[SIDE1-1-k*IN_BITS -: IN_BITS];
            n1_up[k] = n1_side[SIDE1-1-(3+k)*IN_BITS -: IN_BITS];
        end
    end

    // Stage 3: products of cross(up, w)
    logic                         r3_v;
    logic signed [IN_BITS+WW-1:0] r3_x [6];
    logic signed [IN_BITS-1:0]    r3_p [3];
    logic signed [WW-1:0]         r3_w [3];
    logic                         r3_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= n1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_x[0] <= n1_up[1] * n1_w[2];
            r3_x[1] <= n1_up[2] * n1_w[1];
            r3_x[2] <= n1_up[2] * n1_w[0];
            r3_x[3] <= n1_up[0] * n1_w[2];
            r3_x[4] <= n1_up[0] * n1_w[1];
            r3_x[5] <= n1_up[1] * n1_w[0];
            r3_p    <= n1_p;
            r3_w    <= n1_w;
            r3_dg   <= n1_side[0] | n1_zero;
        end
    end

    // Stage 4: cross(up, w)
    logic                      r4_v;
    logic signed [CW-1:0]      r4_cu [3];
    logic signed [IN_BITS-1:0] r4_p [3];
    logic signed [WW-1:0]      r4_w [3];
    logic                      r4_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r4_cu[k] <= CW'(r3_x[2*k]) - CW'(r3_x[2*k+1]);
            end
            r4_p  <= r3_p;
            r4_w  <= r3_w;
            r4_dg <= r3_dg;
        end
    end

    // Normalize cross(up, w) into u
    logic                      n2_v;
    logic signed [WW-1:0]      n2_u [3];
    logic                      n2_zero;
    logic [SIDE2-1:0]          n2_side;
    logic signed [IN_BITS-1:0] n2_p [3];
    logic signed [WW-1:0]      n2_w [3];

    lav_norm #(
        .IN_W   (CW),
        .FRAC   (FRAC_BITS),
        .SIDE_W (SIDE2)
    ) u_norm_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_vec   (r4_cu),
        .i_side  ({r4_p[0], r4_p[1], r4_p[2], r4_w[0], r4_w[1], r4_w[2], r4_dg}),
        .o_valid (n2_v),
        .o_vec   (n2_u),
        .o_zero  (n2_zero),
        .o_side  (n2_side)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n2_p[k] = n2_side[SIDE2-1-k*IN_BITS -: IN_BITS];
            n2_w[k] = n2_side[SIDE2-1-3*IN_BITS-k*WW -: WW];
        end
    end

    // Stage 5: products of cross(w, u)
    logic                      r5_v;
    logic signed [2*WW-1:0]    r5_x [6];
    logic signed [IN_BITS-1:0] r5_p [3];
    logic signed [WW-1:0]      r5_w [3];
    logic signed [WW-1:0]      r5_u [3];
    logic                      r5_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= n2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_x[0] <= n2_w[1] * n2_u[2];
            r5_x[1] <= n2_w[2] * n2_u[1];
            r5_x[2] <= n2_w[2] * n2_u[0];
            r5_x[3] <= n2_w[0] * n2_u[2];
            r5_x[4] <= n2_w[0] * n2_u[1];
            r5_x[5] <= n2_w[1] * n2_u[0];
            r5_p    <= n2_p;
            r5_w    <= n2_w;
            r5_u    <= n2_u;
            r5_dg   <= n2_side[0] | n2_zero;
        end
    end

    // Stage 6: cross(w, u) at double fraction
    logic                      r6_v;
    logic signed [2*WW:0]      r6_vd [3];
    logic signed [IN_BITS-1:0] r6_p [3];
    logic signed [WW-1:0]      r6_w [3];
    logic signed [WW-1:0]      r6_u [3];
    logic                      r6_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r6_vd[k] <= (2*WW+1)'(r5_x[2*k]) - (2*WW+1)'(r5_x[2*k+1]);
            end
            r6_p  <= r5_p;
            r6_w  <= r5_w;
            r6_u  <= r5_u;
            r6_dg <= r5_dg;
        end
    end

    // Stage 7: round v down to the output fraction, half away from zero
    logic                      r7_v;
    logic signed [VW-1:0]      r7_rv [3];
    logic signed [IN_BITS-1:0] r7_p [3];
    logic signed [WW-1:0]      r7_w [3];
    logic signed [WW-1:0]      r7_u [3];
    logic                      r7_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [2*WW:0] mag;
        logic [2*WW:0] rnd;
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                mag = r6_vd[k][2*WW] ? unsigned'(-r6_vd[k]) : unsigned'(r6_vd[k]);
                rnd = (mag + ((2*WW+1)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
                r7_rv[k] <= r6_vd[k][2*WW] ? -signed'(VW'(rnd)) : signed'(VW'(rnd));
            end
            r7_p  <= r6_p;
            r7_w  <= r6_w;
            r7_u  <= r6_u;
            r7_dg <= r6_dg;
        end
    end

    // Stage 8: dot-product terms of u, v, w with p
    logic                 r8_v;
    logic signed [PW-1:0] r8_x [3][3];
    logic signed [VW-1:0] r8_rot [3][3];
    logic                 r8_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r8_rot[0][k] <= VW'(r7_u[k]);
                r8_rot[1][k] <= r7_rv[k];
                r8_rot[2][k] <= VW'(r7_w[k]);
                r8_x[0][k]   <= VW'(r7_u[k]) * r7_p[k];
                r8_x[1][k]   <= r7_rv[k] * r7_p[k];
                r8_x[2][k]   <= VW'(r7_w[k]) * r7_p[k];
            end
            r8_dg <= r7_dg;
        end
    end

    // Stage 9: sum the dot products
    logic                  r9_v;
    logic signed [DSW-1:0] r9_d [3];
    logic signed [VW-1:0]  r9_rot [3][3];
    logic                  r9_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (en) begin
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r9_d[i] <= DSW'(r8_x[i][0]) + DSW'(r8_x[i][1]) + DSW'(r8_x[i][2]);
            end
            r9_rot <= r8_rot;
            r9_dg  <= r8_dg;
        end
    end

    // Stage 10: round the dot products to Q16.16 and negate
    logic                  r10_v;
    logic signed [TRW-1:0] r10_t [3];
    logic signed [VW-1:0]  r10_rot [3][3];
    logic                  r10_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (en) begin
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [DSW-1:0] mag;
        logic [DSW-1:0] rnd;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag = r9_d[i][DSW-1] ? unsigned'(-r9_d[i]) : unsigned'(r9_d[i]);
                rnd = (mag + (DSW'(1) << (IN_FRAC-1))) >> IN_FRAC;
                r10_t[i] <= r9_d[i][DSW-1] ? signed'(TRW'(rnd)) : -signed'(TRW'(rnd));
            end
            r10_rot <= r9_rot;
            r10_dg  <= r9_dg;
        end
    end

    // Stage 11: saturate, or substitute the identity when degenerate
    logic                 r11_v;
    logic [WORD_BITS-1:0] r11_ent [4][4];
    logic                 r11_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else if (en) begin
            r11_v <= r10_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    if (r10_dg || i == 3) begin
                        r11_ent[i][j] <= sat((i == j) ? ONE : EW'(0));
                    end else if (j == 3) begin
                        r11_ent[i][j] <= sat(EW'(r10_t[i]));
                    end else begin
                        r11_ent[i][j] <= sat(EW'(r10_rot[i][j]));
                    end
                end
            end
            r11_dg <= r10_dg;
        end
    end

    // Row serializer: hold one matrix, hand out one row per transaction
    logic                 r_busy;
    t_row_idx             r_row;
    logic [WORD_BITS-1:0] r_rows [4][4];
    logic                 r_dg;

    assign load    = r11_v && (!r_busy || (i_ready && r_row == LAST_ROW));
    assign en      = !r11_v || load;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_row  <= '0;
            end else if (r_busy && i_ready) begin
                if (r_row == LAST_ROW) begin
                    r_busy <= 1'b0;
                end
                r_row <= r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rows <= r11_ent;
            r_dg   <= r11_dg;
        end
    end

    assign o_valid      = r_busy;
    assign o_row_index  = r_row;
    assign o_col0       = r_rows[r_row][0];
    assign o_col1       = r_rows[r_row][1];
    assign o_col2       = r_rows[r_row][2];
    assign o_col3       = r_rows[r_row][3];
    assign o_degenerate = r_dg;
    assign o_last_row   = (r_row == LAST_ROW);

endmodule

[dv/look_at_view_matrix_test.sv]
// ----------------------------------------------------------------------------
// look_at_view_matrix_test: self-checking bench for the look-at view matrix
// Sends camera position, view and up vectors with random gaps, predicts the
// four rows of each view matrix in fixed point and compares every row that
// comes out, field by field, under random backpressure.
// ----------------------------------------------------------------------------
module look_at_view_matrix_test;
    import lav_pkg::*;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 300;

    typedef struct {
        t_row_idx          row;
        logic [WORD_BITS-1:0] c0, c1, c2, c3;
        logic              degen;
        logic              last;
    } t_view_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    logic signed [IN_BITS-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [IN_BITS-1:0] i_view_x, i_view_y, i_view_z;
    logic signed [IN_BITS-1:0] i_up_x, i_up_y, i_up_z;
    logic o_valid;
    logic i_ready;
    t_row_idx o_row_index;
    logic signed [WORD_BITS-1:0] o_col0, o_col1, o_col2, o_col3;
    logic o_degenerate;
    logic o_last_row;

    t_view_row pending_rows[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  steady = 0;
    int  ready_hold = 0;

    look_at_view_matrix #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) dut (.*);

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pick a gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------- fixed-point predictor ----------------
    function automatic longint unsigned magnitude(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit unit_vector(input longint a[3], output longint o[3]);
        longint unsigned m[3];
        longint unsigned mx, s, n, q;
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = magnitude(a[i]);
            if (m[i] > mx) mx = m[i];
            o[i] = 0;
        end
        if (mx == 0) return 0;
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
        n = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC_BITS) + (n >> 1)) / n;
            o[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic longint round_away(longint x, int sh);
        longint unsigned m;
        m = (magnitude(x) + (64'd1 << (sh - 1))) >> sh;
        return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [WORD_BITS-1:0] clamp_word(longint x);
        longint hi, lo;
        hi = (longint'(1) << (WORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        return x[WORD_BITS-1:0];
    endfunction

    function automatic void cross_product(input longint a[3], input longint b[3],
                                          output longint r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Push the four expected rows of one view matrix
    function automatic void predict_view_rows(longint p[3], longint vw[3], longint up[3]);
        longint nw[3], w[3], cu[3], u[3], v[3], prod[3], mat[4][4], d;
        bit degen;
        t_view_row r;
        for (int i = 0; i < 3; i++) nw[i] = -vw[i];
        degen = (up[1] * vw[2] == up[2] * vw[1]) && (up[2] * vw[0] == up[0] * vw[2]) &&
                (up[0] * vw[1] == up[1] * vw[0]);
        if (!unit_vector(nw, w)) degen = 1;
        if (!degen) begin
            cross_product(up, w, cu);
            if (!unit_vector(cu, u)) degen = 1;
        end
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                mat[i][j] = (i == j) ? (longint'(1) << FRAC_BITS) : 0;
        if (!degen) begin
            cross_product(w, u, prod);
            for (int i = 0; i < 3; i++) v[i] = round_away(prod[i], FRAC_BITS);
            for (int j = 0; j < 3; j++) begin
                mat[0][j] = u[j];
                mat[1][j] = v[j];
                mat[2][j] = w[j];
            end
            for (int i = 0; i < 3; i++) begin
                d = mat[i][0] * p[0] + mat[i][1] * p[1] + mat[i][2] * p[2];
                mat[i][3] = -round_away(d, IN_FRAC);
            end
        end
        for (int i = 0; i < 4; i++) begin
            r.row   = t_row_idx'(i);
            r.c0    = clamp_word(mat[i][0]);
            r.c1    = clamp_word(mat[i][1]);
            r.c2    = clamp_word(mat[i][2]);
            r.c3    = clamp_word(mat[i][3]);
            r.degen = degen;
            r.last  = (t_row_idx'(i) == LAST_ROW);
            pending_rows.push_back(r);
        end
    endfunction

    // ---------------- stimulus ----------------
    // Send one camera transaction, then record its expected rows
    task automatic send_camera(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                               logic [31:0] ux, logic [31:0] uy, logic [31:0] uz);
        int gap;
        longint p[3], vw[3], up[3];
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_pos_x  <= px;  i_pos_y  <= py;  i_pos_z  <= pz;
        i_view_x <= vx;  i_view_y <= vy;  i_view_z <= vz;
        i_up_x   <= ux;  i_up_y   <= uy;  i_up_z   <= uz;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        p  = '{longint'($signed(px)), longint'($signed(py)), longint'($signed(pz))};
        vw = '{longint'($signed(vx)), longint'($signed(vy)), longint'($signed(vz))};
        up = '{longint'($signed(ux)), longint'($signed(uy)), longint'($signed(uz))};
        predict_view_rows(p, vw, up);
    endtask

    task automatic test_directed();
        localparam logic [31:0] ONE = 32'h0001_0000;
        localparam logic [31:0] MONE = 32'hFFFF_0000;
        localparam logic [31:0] MAXW = 32'h7FFF_FFFF;
        localparam logic [31:0] MINW = 32'h8000_0000;
        steady = 0;
        // Standard camera looking down -z
        send_camera(0, 0, 0, 0, 0, MONE, 0, ONE, 0);
        send_camera(ONE, 32'h0002_0000, 32'h0003_8000, 0, 0, MONE, 0, ONE, 0);
        // Zero view and zero up
        send_camera(ONE, ONE, ONE, 0, 0, 0, 0, ONE, 0);
        send_camera(ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0);
        // Up parallel and anti-parallel to view
        send_camera(0, 0, 0, ONE, ONE, 0, 32'h0002_0000, 32'h0002_0000, 0);
        send_camera(0, 0, 0, ONE, ONE, ONE, MONE, MONE, MONE);
        // Field extremes
        send_camera(MAXW, MAXW, MAXW, MAXW, MINW, MAXW, MINW, MAXW, MINW);
        send_camera(MINW, MINW, MINW, MINW, MAXW, MINW, MAXW, MINW, MAXW);
        send_camera(MAXW, MINW, MAXW, 1, 0, 0, 0, 1, 0);
        send_camera(MINW, MAXW, MINW, 0, MINW, 0, MAXW, 0, 0);
        send_camera(32'hFFFF_FFFF, 1, 0, MINW, MINW, MINW, 1, 0, 0);
        // Tiny vectors, nearly parallel up
        send_camera(ONE, 0, 0, 1, 0, 0, 1, 1, 0);
        send_camera(0, 0, 0, MAXW, 1, 0, MAXW, 0, 0);
        send_camera(MAXW, MAXW, MAXW, 0, 0, 1, 1, 0, MAXW);
        // Back to back with no gaps
        steady = 1;
        for (int i = 0; i < 6; i++)
            send_camera($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom);
        steady = 0;
    endtask

    function automatic logic [31:0] scaled_word();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2: return $signed($urandom_range(0, 64)) - 32;
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                                 : 32'h8000_0000 + $urandom_range(0, 3);
        endcase
    endfunction

    task automatic test_random();
        logic [31:0] v[3], u[3];
        int k;
        for (int n = 0; n < 300; n++) begin
            if (n % 100 == 50) steady = 1;
            if (n % 100 == 80) steady = 0;
            for (int i = 0; i < 3; i++) v[i] = scaled_word();
            case ($urandom_range(0, 9))
                0: begin
                    // Up a small multiple of view
                    k = $urandom_range(0, 4) - 2;
                    for (int i = 0; i < 3; i++) begin
                        v[i] = $signed($urandom_range(0, 2000)) - 1000;
                        u[i] = v[i] * k;
                    end
                end
                1: begin
                    // Up close to view
                    for (int i = 0; i < 3; i++)
                        u[i] = v[i] + $signed($urandom_range(0, 2)) - 1;
                end
                2: begin
                    for (int i = 0; i < 3; i++) u[i] = scaled_word();
                    v[$urandom_range(0, 2)] = 0;
                    if ($urandom_range(0, 3) == 0) v = '{0, 0, 0};
                end
                default: for (int i = 0; i < 3; i++) u[i] = scaled_word();
            endcase
            send_camera(scaled_word(), scaled_word(), scaled_word(),
                        v[0], v[1], v[2], u[0], u[1], u[2]);
        end
    endtask

    // ---------------- result side ----------------
    // Drive backpressure with random stalls
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_ready    <= 1'b0;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            ready_hold <= pick_gap();
            i_ready    <= 1'b0;
        end else begin
            i_ready    <= 1'b1;
        end
    end

    // Compare each row transaction with the oldest expected row
    always @(posedge i_clk) begin
        t_view_row e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rows.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row %0d: %h %h %h %h", o_row_index,
                             o_col0, o_col1, o_col2, o_col3);
            end else begin
                e = pending_rows.pop_front();
                if (o_row_index !== e.row || o_col0 !== e.c0 || o_col1 !== e.c1 ||
                    o_col2 !== e.c2 || o_col3 !== e.c3 || o_degenerate !== e.degen ||
                    o_last_row !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"row mismatch exp %0d %h %h %h %h d%b l%b",
                                  " got %0d %h %h %h %h d%b l%b"},
                                 e.row, e.c0, e.c1, e.c2, e.c3, e.degen, e.last,
                                 o_row_index, o_col0, o_col1, o_col2, o_col3,
                                 o_degenerate, o_last_row);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("look_at_view_matrix_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sequence the tests
    initial begin
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_pos_x  <= '0;  i_pos_y  <= '0;  i_pos_z  <= '0;
        i_view_x <= '0;  i_view_y <= '0;  i_view_z <= '0;
        i_up_x   <= '0;  i_up_y   <= '0;  i_up_z   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        i_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && pending_rows.size() == 0) begin
            $display("look_at_view_matrix_test: clean");
        end else begin
            $display("look_at_view_matrix_test: errors");
        end
        $finish;
    end

endmodule
